[rtl/bmoc_pkg.sv]
// ----------------------------------------------------------------------------
// bmoc_pkg: shared types and codes for the bracket matching op compiler
// op codes, result kinds, error codes and the result record
// ----------------------------------------------------------------------------
package bmoc_pkg;

  // default sizes
  localparam int DEF_TABLE_SLOTS = 4096;
  localparam int DEF_MAX_NESTING = 64;
  localparam int DEF_COUNT_BITS  = 16;

  // fixed field widths of a result beat
  localparam int SLOT_W = 12;
  localparam int VAL_W  = 16;
  localparam int CHAR_W = 8;
  localparam int DATA_W = 40;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_PATCH  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // op codes, with an extra none marker
  localparam logic [3:0] OP_LEFT  = 4'd0;
  localparam logic [3:0] OP_RIGHT = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_READ  = 4'd4;
  localparam logic [3:0] OP_WRITE = 4'd5;
  localparam logic [3:0] OP_LOOP  = 4'd6;
  localparam logic [3:0] OP_END   = 4'd7;
  localparam logic [3:0] OP_NONE  = 4'd8;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_UNMATCHED = 3'd1;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd2;
  localparam logic [2:0] ERR_FULL      = 3'd3;
  localparam logic [2:0] ERR_DEEP      = 3'd4;

  // source characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        opcode;
    logic [VAL_W-1:0]  value;
    logic [2:0]        err;
    logic              last;
  } res_t;

  function automatic logic [3:0] simple_op(input logic [7:0] c);
    logic [3:0] op;
    case (c)
      CH_LT:    op = OP_LEFT;
      CH_GT:    op = OP_RIGHT;
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_COMMA: op = OP_READ;
      CH_DOT:   op = OP_WRITE;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

[rtl/bmoc_ram.sv]
// ----------------------------------------------------------------------------
// bmoc_ram: generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bmoc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bmoc_out_buf.sv]
// ----------------------------------------------------------------------------
// bmoc_out_buf: two entry result buffer
// takes up to two results per cycle as space allows; while out_ready holds, hands out one beat per cycle
// ----------------------------------------------------------------------------
module bmoc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  bmoc_pkg::res_t   push0,
  input  bmoc_pkg::res_t   push1,
  output logic [1:0]       space,
  output logic             out_valid,
  input  logic             out_ready,
  output bmoc_pkg::res_t   out_res
);
  import bmoc_pkg::*;

  res_t       ent_r [2];
  res_t       ent_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_left;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = ent_r[0];
  // a beat leaving this cycle frees its entry for a push in the same cycle
  assign space     = 2'd2 - cnt_r + {1'b0, pop};
  assign pop       = out_valid && out_ready;

  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    cnt_left   = cnt_r - {1'b0, pop};
    if (pop) begin
      ent_nxt[0] = ent_r[1];
    end
    if (push_n != 2'd0) begin
      if (cnt_left == 2'd0) begin
        ent_nxt[0] = push0;
      end else begin
        ent_nxt[1] = push0;
      end
    end
    // a two result push only happens when the buffer is empty after the pop
    if (push_n == 2'd2) begin
      ent_nxt[1] = push1;
    end
    cnt_nxt = cnt_left + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

endmodule

[rtl/bracket_matching_op_compiler.sv]
// ----------------------------------------------------------------------------
// bracket_matching_op_compiler: run-length op table compiler
// turns program text into op table writes, pairs brackets through a stack
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  in_     | in  | tdata: char_in; tlast: end_mark
//  out_    | out | tdata: slot, opcode, op_value, error_code; tuser: kind;
//          |     | tlast: last
//
//  - a source byte is registered, decoded combinationally and its results go to
//    a two entry output buffer; with room there, a new byte is taken every cycle
//  - a close bracket gives two beats, so a run of them is limited by the single
//    beat per cycle output port
//  - the open bracket stack is a ram read at the current top every cycle; a
//    pushed slot is forwarded for the cycle after its write
//  - in_tready sees out_tready only through the buffer pop, so a beat leaving
//    a full buffer makes room for the next byte in the same cycle
//  - synchronous active low reset clears all control state; the stack ram is
//    not cleared, only pushed entries are read
//
module bracket_matching_op_compiler #(
  parameter int TABLE_SLOTS = bmoc_pkg::DEF_TABLE_SLOTS,
  parameter int MAX_NESTING = bmoc_pkg::DEF_MAX_NESTING,
  parameter int COUNT_BITS  = bmoc_pkg::DEF_COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bmoc_pkg::CHAR_W-1:0] in_tdata,   // [7:0] char_in
  input  logic                        in_tlast,   // end_mark
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [11:0] slot, [14:12] opcode, [30:15] op_value, [33:31] error_code, rest zero
  output logic [bmoc_pkg::DATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast   // last
);
  import bmoc_pkg::*;

  localparam int NSW = $clog2(TABLE_SLOTS + 1);   // next slot counter
  localparam int SW  = $clog2(TABLE_SLOTS);       // stored slot
  localparam int DW  = $clog2(MAX_NESTING + 1);   // stack depth counter
  localparam int AW  = $clog2(MAX_NESTING);       // stack ram address
  localparam int LCW = (COUNT_BITS > VAL_W) ? VAL_W : COUNT_BITS;

  // input register
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_end_r;

  // compiler state
  logic [DW-1:0]  depth_r,   depth_nxt;
  logic [NSW-1:0] slot_r,    slot_nxt;
  logic [3:0]     lop_r,     lop_nxt;
  logic [LCW-1:0] lcnt_r,    lcnt_nxt;
  logic [2:0]     err_r,     err_nxt;

  // stack ram and its forwarding path
  logic           push;
  logic [SW-1:0]  ram_rdata;
  logic [AW-1:0]  ram_raddr;
  logic [DW-1:0]  depth_upd;
  logic           fwd_r;
  logic [SW-1:0]  fwd_data_r;
  logic [SW-1:0]  top_slot;

  // decode
  logic [3:0] sop;
  logic       full;
  logic [1:0] n;
  res_t       r0, r1;

  // output buffer
  logic [1:0] space;
  logic       proc_fire;
  res_t       out_res;

  assign proc_fire = in_valid_r && (n <= space);
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  assign sop      = simple_op(in_char_r);
  assign full     = (slot_r >= NSW'(TABLE_SLOTS));
  assign top_slot = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    push      = 1'b0;
    depth_nxt = depth_r;
    slot_nxt  = slot_r;
    lop_nxt   = lop_r;
    lcnt_nxt  = lcnt_r;
    err_nxt   = err_r;
    if (in_end_r) begin
      // status beat, then back to the reset state
      n        = 2'd1;
      r0.kind  = KIND_STATUS;
      r0.value = VAL_W'(slot_r);
      r0.err   = (err_r == ERR_OK && depth_r != '0) ? ERR_UNCLOSED : err_r;
      r0.last  = 1'b1;
      depth_nxt = '0;
      slot_nxt  = '0;
      lop_nxt   = OP_NONE;
      lcnt_nxt  = '0;
      err_nxt   = ERR_OK;
    end else if (err_r != ERR_OK) begin
      // swallow everything up to the end mark
    end else if (in_char_r == CH_OPEN) begin
      if (full) begin
        err_nxt = ERR_FULL;
      end else if (depth_r == DW'(MAX_NESTING)) begin
        err_nxt = ERR_DEEP;
      end else begin
        push       = 1'b1;
        n          = 2'd1;
        r0.kind    = KIND_WRITE;
        r0.slot    = SLOT_W'(slot_r);
        r0.opcode  = OP_LOOP[2:0];
        r0.last    = 1'b1;
        depth_nxt  = depth_r + 1'b1;
        slot_nxt   = slot_r + 1'b1;
        lop_nxt    = OP_LOOP;
        lcnt_nxt   = '0;
      end
    end else if (in_char_r == CH_CLOSE) begin
      if (depth_r == '0) begin
        err_nxt = ERR_UNMATCHED;
      end else if (full) begin
        err_nxt = ERR_FULL;
      end else begin
        // patch the loop entry, then write the end entry pointing back
        n          = 2'd2;
        r0.kind    = KIND_PATCH;
        r0.slot    = SLOT_W'(top_slot);
        r0.opcode  = OP_LOOP[2:0];
        r0.value   = VAL_W'(slot_r);
        r1.kind    = KIND_WRITE;
        r1.slot    = SLOT_W'(slot_r);
        r1.opcode  = OP_END[2:0];
        r1.value   = VAL_W'(top_slot);
        r1.last    = 1'b1;
        depth_nxt  = depth_r - 1'b1;
        slot_nxt   = slot_r + 1'b1;
        lop_nxt    = OP_END;
        lcnt_nxt   = '0;
      end
    end else if (sop != OP_NONE) begin
      if (slot_r != '0 && lop_r == sop) begin
        // extend the run, saturating at all ones
        lcnt_nxt  = (&lcnt_r) ? lcnt_r : lcnt_r + 1'b1;
        n         = 2'd1;
        r0.kind   = KIND_WRITE;
        r0.slot   = SLOT_W'(slot_r - 1'b1);
        r0.opcode = sop[2:0];
        r0.value  = VAL_W'(lcnt_nxt);
        r0.last   = 1'b1;
      end else if (full) begin
        err_nxt = ERR_FULL;
      end else begin
        n         = 2'd1;
        r0.kind   = KIND_WRITE;
        r0.slot   = SLOT_W'(slot_r);
        r0.opcode = sop[2:0];
        r0.value  = VAL_W'(1);
        r0.last   = 1'b1;
        lop_nxt   = sop;
        lcnt_nxt  = LCW'(1);
        slot_nxt  = slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      slot_r  <= '0;
      lop_r   <= OP_NONE;
      lcnt_r  <= '0;
      err_r   <= ERR_OK;
      fwd_r   <= 1'b0;
    end else begin
      if (proc_fire) begin
        depth_r <= depth_nxt;
        slot_r  <= slot_nxt;
        lop_r   <= lop_nxt;
        lcnt_r  <= lcnt_nxt;
        err_r   <= err_nxt;
      end
      // the ram reads the new top in the same cycle it is written
      fwd_r <= proc_fire && push;
    end
    if (proc_fire && push) begin
      fwd_data_r <= SW'(slot_r);
    end
  end

  // keep the read port on the top entry of the stack as it will be next cycle
  assign depth_upd = proc_fire ? depth_nxt : depth_r;
  assign ram_raddr = (depth_upd == '0) ? '0 : AW'(depth_upd - 1'b1);

  bmoc_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_NESTING)
  ) u_stack (
    .clk   (clk),
    .we    (proc_fire && push),
    .waddr (depth_r[AW-1:0]),
    .wdata (SW'(slot_r)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmoc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (proc_fire ? n : 2'd0),
    .push0     (r0),
    .push1     (r1),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'b0, out_res.err, out_res.value, out_res.opcode, out_res.slot};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // end mark must leave the block in its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && in_end_r |=> depth_r == '0 && slot_r == '0 && err_r == ERR_OK)
    else $error("state not cleared after end mark");

  // after an error only the end mark may produce beats
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && !in_end_r && err_r != ERR_OK |-> n == 2'd0)
    else $error("beat produced while an error is latched");

  // stack never grows past its size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_NESTING))
    else $error("stack depth out of range");

endmodule
